FILE: sv/i2cdw_pkg.sv
// Shared types and constants of the I2C display command writer.
// No dependencies; the front, queue, back and core files import it.
package i2cdw_pkg;

    // Request opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_DATA   = 3'd2;
    localparam logic [2:0] OP_PAGE   = 3'd3;
    localparam logic [2:0] OP_COLUMN = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
    localparam logic [1:0] CFG_COL_OFS   = 2'd1;
    localparam logic [1:0] CFG_ACK_LIMIT = 2'd2;

    // Register reset values
    localparam logic [7:0] DEV_ADDR_RST  = 8'h78;
    localparam logic [6:0] COL_OFS_RST   = 7'd28;
    localparam logic [7:0] ACK_LIMIT_RST = 8'hFF;

    // Protocol bytes
    localparam logic [7:0] CTRL_CMD    = 8'h00;
    localparam logic [7:0] CTRL_DATA   = 8'h40;
    localparam logic [7:0] PAGE_BASE   = 8'hB0;
    localparam logic [7:0] COL_HIGH    = 8'h10;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] ACK_CNT_MAX = 8'hFF;

    // Classified tick handed from the front end to the sequencer
    typedef struct packed {
        logic       req;          // a job request (opcode 1 to 4)
        logic       is_data;
        logic [7:0] payload;
        logic       second;       // set column: a second command follows
        logic [7:0] second_byte;
        logic       sda_in;
    } cmd_t;

endpackage

FILE: sv/i2cdw_front.sv
// Front end: decodes one tick's opcode into a job request with its bytes.
// Depends on i2cdw_pkg.
module i2cdw_front (
    input  logic [2:0]        opcode,
    input  logic [7:0]        value,
    input  logic              sda_in,
    input  logic [6:0]        column_offset,
    output i2cdw_pkg::cmd_t   cmd
);
    import i2cdw_pkg::*;

    logic [7:0] col;

    assign col = value + {1'b0, column_offset};

    always_comb begin
        cmd             = '0;
        cmd.sda_in      = sda_in;
        case (opcode)
            OP_CMD: begin
                cmd.req     = 1'b1;
                cmd.payload = value;
            end
            OP_DATA: begin
                cmd.req     = 1'b1;
                cmd.is_data = 1'b1;
                cmd.payload = value;
            end
            OP_PAGE: begin
                cmd.req     = 1'b1;
                cmd.payload = PAGE_BASE | value;
            end
            OP_COLUMN: begin
                cmd.req         = 1'b1;
                cmd.payload     = COL_HIGH | {4'b0, col[7:4]};
                cmd.second      = 1'b1;
                cmd.second_byte = col & NIBBLE_MASK;
            end
            default: begin
                cmd.req = 1'b0;   // tick only, unused codes too
            end
        endcase
    end

endmodule

FILE: sv/i2cdw_queue.sv
// Short FIFO of classified ticks between front end and sequencer.
// Depends on i2cdw_pkg.
module i2cdw_queue #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  i2cdw_pkg::cmd_t   wr_data,
    output logic              full,
    input  logic              rd_en,
    output i2cdw_pkg::cmd_t   rd_data,
    output logic              empty
);
    import i2cdw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: sv/i2cdw_back.sv
// Back end: bit-level I2C sequencer, one phase step per tick, and the
// result register. Depends on i2cdw_pkg.
module i2cdw_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    input  i2cdw_pkg::cmd_t   cmd,
    output logic              cmd_pop,
    input  logic [7:0]        device_address,
    input  logic [7:0]        ack_wait_limit,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_scl_level,
    output logic              m_sda_level,
    output logic              m_busy_res,
    output logic              m_ack_timeout,
    output logic              m_job_done
);
    import i2cdw_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START0, PH_START1, PH_START2, PH_START3,
        PH_BIT_LOW, PH_BIT_DATA, PH_BIT_HIGH, PH_BYTE_END,
        PH_ACK_REL, PH_ACK_SCL, PH_ACK_WAIT, PH_ACK_END,
        PH_STOP0, PH_STOP1, PH_STOP2, PH_STOP3
    } phase_t;

    phase_t     phase_reg, phase_next, ph;
    logic [3:0] bit_cnt_reg, bit_cnt_next, bit_cnt_inc;
    logic [1:0] byte_cnt_reg, byte_cnt_next, byte_cnt_inc;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] payload_reg, payload_next;
    logic       is_data_reg, is_data_next;
    logic [7:0] ack_cnt_reg, ack_cnt_next, ack_cnt_inc;
    logic       second_reg, second_next;
    logic [7:0] second_byte_reg, second_byte_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       busy, timeout, done;
    logic       m_valid_reg;
    logic       scl_out_reg, sda_out_reg, busy_out_reg, timeout_out_reg, done_out_reg;

    assign cmd_pop      = cmd_valid && (!m_valid_reg || m_ready);
    assign bit_cnt_inc  = bit_cnt_reg + 1'b1;
    assign byte_cnt_inc = byte_cnt_reg + 1'b1;
    assign ack_cnt_inc  = (ack_cnt_reg == ACK_CNT_MAX) ? ACK_CNT_MAX : ack_cnt_reg + 1'b1;

    always_comb begin
        ph               = phase_reg;
        bit_cnt_next     = bit_cnt_reg;
        byte_cnt_next    = byte_cnt_reg;
        shift_next       = shift_reg;
        payload_next     = payload_reg;
        is_data_next     = is_data_reg;
        ack_cnt_next     = ack_cnt_reg;
        second_next      = second_reg;
        second_byte_next = second_byte_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        busy             = 1'b0;
        timeout          = 1'b0;
        done             = 1'b0;

        // A request is taken only when idle; otherwise it is dropped
        if (phase_reg == PH_IDLE && cmd.req) begin
            second_next  = cmd.second;
            is_data_next = cmd.is_data;
            payload_next = cmd.payload;
            if (cmd.second) begin
                second_byte_next = cmd.second_byte;
            end
            ph = PH_START0;
        end
        phase_next = ph;

        if (ph != PH_IDLE) begin
            busy = 1'b1;
            case (ph)
                PH_START0: begin
                    sda_next   = 1'b1;
                    phase_next = PH_START1;
                end
                PH_START1: begin
                    scl_next   = 1'b1;
                    phase_next = PH_START2;
                end
                PH_START2: begin
                    sda_next   = 1'b0;
                    phase_next = PH_START3;
                end
                PH_START3: begin
                    scl_next      = 1'b0;
                    byte_cnt_next = '0;
                    bit_cnt_next  = '0;
                    shift_next    = device_address;
                    phase_next    = PH_BIT_LOW;
                end
                PH_BIT_LOW: begin
                    scl_next   = 1'b0;
                    phase_next = PH_BIT_DATA;
                end
                PH_BIT_DATA: begin
                    sda_next   = shift_reg[7];
                    phase_next = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    scl_next     = 1'b1;
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_cnt_inc;
                    phase_next   = (bit_cnt_inc >= 4'd8) ? PH_BYTE_END : PH_BIT_LOW;
                end
                PH_BYTE_END: begin
                    scl_next   = 1'b0;
                    phase_next = PH_ACK_REL;
                end
                PH_ACK_REL: begin
                    sda_next     = 1'b1;
                    ack_cnt_next = '0;
                    phase_next   = PH_ACK_SCL;
                end
                PH_ACK_SCL: begin
                    scl_next   = 1'b1;
                    phase_next = PH_ACK_WAIT;
                end
                PH_ACK_WAIT: begin
                    ack_cnt_next = ack_cnt_inc;
                    if (!cmd.sda_in) begin
                        phase_next = PH_ACK_END;
                    end else if (ack_cnt_inc >= ack_wait_limit) begin
                        timeout    = 1'b1;
                        phase_next = PH_ACK_END;
                    end
                end
                PH_ACK_END: begin
                    scl_next      = 1'b0;
                    byte_cnt_next = byte_cnt_inc;
                    if (byte_cnt_inc == 2'd3 || byte_cnt_inc == 2'd0) begin
                        phase_next = PH_STOP0;
                    end else begin
                        bit_cnt_next = '0;
                        // slot 1 is the control byte, slot 2 the payload
                        if (byte_cnt_inc == 2'd1) begin
                            shift_next = is_data_reg ? CTRL_DATA : CTRL_CMD;
                        end else begin
                            shift_next = payload_reg;
                        end
                        phase_next = PH_BIT_LOW;
                    end
                end
                PH_STOP0: begin
                    scl_next   = 1'b0;
                    phase_next = PH_STOP1;
                end
                PH_STOP1: begin
                    sda_next   = 1'b0;
                    phase_next = PH_STOP2;
                end
                PH_STOP2: begin
                    scl_next   = 1'b1;
                    phase_next = PH_STOP3;
                end
                PH_STOP3: begin
                    sda_next = 1'b1;
                    if (second_reg) begin
                        second_next  = 1'b0;
                        payload_next = second_byte_reg;
                        is_data_next = 1'b0;
                        phase_next   = PH_START0;
                    end else begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            bit_cnt_reg     <= '0;
            byte_cnt_reg    <= '0;
            shift_reg       <= '0;
            payload_reg     <= '0;
            is_data_reg     <= 1'b0;
            ack_cnt_reg     <= '0;
            second_reg      <= 1'b0;
            second_byte_reg <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd_pop) begin
                phase_reg       <= phase_next;
                bit_cnt_reg     <= bit_cnt_next;
                byte_cnt_reg    <= byte_cnt_next;
                shift_reg       <= shift_next;
                payload_reg     <= payload_next;
                is_data_reg     <= is_data_next;
                ack_cnt_reg     <= ack_cnt_next;
                second_reg      <= second_next;
                second_byte_reg <= second_byte_next;
                scl_reg         <= scl_next;
                sda_reg         <= sda_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            scl_out_reg     <= scl_next;
            sda_out_reg     <= sda_next;
            busy_out_reg    <= busy;
            timeout_out_reg <= timeout;
            done_out_reg    <= done;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_scl_level   = scl_out_reg;
    assign m_sda_level   = sda_out_reg;
    assign m_busy_res    = busy_out_reg;
    assign m_ack_timeout = timeout_out_reg;
    assign m_job_done    = done_out_reg;

endmodule

FILE: sv/i2c_display_command_writer_core.sv
// An accepted request is written into the queue; the sequencer pops it, steps and
// registers the outcome in the result register, which m_ready can stall.
// Throughput: one tick, one sequencer phase, per cycle unless m_ready stalls.
// The queue keeps taking requests while a result waits on m_ready, until full.
// Reset (aresetn low, synchronous): sequencer idle, SCL and SDA released,
// queue empty, registers back to address 0x78, offset 28, ack limit 255.
module i2c_display_command_writer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [7:0] s_value,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_busy_res,
    output logic       m_ack_timeout,
    output logic       m_job_done,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata
);
    import i2cdw_pkg::*;

    logic [7:0] dev_addr_reg;
    logic [6:0] col_ofs_reg;
    logic [7:0] ack_limit_reg;
    cmd_t       front_cmd, q_cmd;
    logic       q_full, q_empty, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg  <= DEV_ADDR_RST;
            col_ofs_reg   <= COL_OFS_RST;
            ack_limit_reg <= ACK_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEV_ADDR:  dev_addr_reg  <= cfg_wdata;
                CFG_COL_OFS:   col_ofs_reg   <= cfg_wdata[6:0];
                CFG_ACK_LIMIT: ack_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;

    i2cdw_front u_front (
        .opcode        (s_opcode),
        .value         (s_value),
        .sda_in        (s_sda_in),
        .column_offset (col_ofs_reg),
        .cmd           (front_cmd)
    );

    i2cdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_valid && !q_full),
        .wr_data (front_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    i2cdw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (!q_empty),
        .cmd            (q_cmd),
        .cmd_pop        (q_pop),
        .device_address (dev_addr_reg),
        .ack_wait_limit (ack_limit_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_level    (m_scl_level),
        .m_sda_level    (m_sda_level),
        .m_busy_res     (m_busy_res),
        .m_ack_timeout  (m_ack_timeout),
        .m_job_done     (m_job_done)
    );

endmodule

FILE: sv/i2cdw_checker.sv
// Port-level checks of the I2C display command writer, bound to the top.
// Depends on i2c_display_command_writer_core only through its ports.
module i2cdw_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_scl_level,
    input logic m_sda_level,
    input logic m_busy_res,
    input logic m_ack_timeout,
    input logic m_job_done
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scl_level) && $stable(m_sda_level)
            && $stable(m_busy_res) && $stable(m_ack_timeout) && $stable(m_job_done))
        else $error("result changed while stalled");

    // end of a job is the stop: both lines released, still counted busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_job_done |-> m_busy_res && m_scl_level && m_sda_level)
        else $error("job_done outside a released stop");

    // timeout happens mid-acknowledge: SCL high, SDA released
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ack_timeout |-> m_busy_res && m_scl_level && m_sda_level)
        else $error("ack_timeout outside an acknowledge wait");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ack_timeout |-> !m_job_done)
        else $error("timeout and job_done on the same tick");

endmodule

bind i2c_display_command_writer_core i2cdw_checker u_i2cdw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_scl_level   (m_scl_level),
    .m_sda_level   (m_sda_level),
    .m_busy_res    (m_busy_res),
    .m_ack_timeout (m_ack_timeout),
    .m_job_done    (m_job_done)
);
